// ----- sv/tbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Three-band tone control: shared package
// Widths, coefficients, register indexes and the microcode table that the
// sequencer plays for every sample.
// ----------------------------------------------------------------------------
package tbc_pkg;

  localparam int unsigned TBC_CHANNELS = 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned GAIN_W     = 14;
  localparam int unsigned HEAD_W     = 13;
  localparam int unsigned VOL_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADROOM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME    = 3'd4;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 14'd4096;
  localparam logic [HEAD_W-1:0] HEAD_UNITY = 13'd4096;
  localparam logic [VOL_W-1:0]  VOL_FULL   = 8'd255;

  // multiplier: signed A by unsigned B, registered product
  localparam int unsigned AW    = 38;
  localparam int unsigned BW    = 23;
  localparam int unsigned PW    = 62;
  localparam int unsigned ACC_W = 49;
  localparam int unsigned MAG_W = 48;
  localparam int unsigned T_W   = 37;

  localparam logic [15:0]   C_SLOW    = 16'd1842;
  localparam logic [15:0]   C_FAST    = 16'd28508;
  localparam logic [24:0]   RECIP_255 = 25'd16843010;
  localparam logic [BW-1:0] M_CLAMP   = 23'd8356095;

  localparam logic [15:0] POS_LIMIT = 16'd32767;
  localparam logic [15:0] NEG_LIMIT = 16'd32768;
  localparam logic [15:0] OUT_MAX   = 16'h7FFF;
  localparam logic [15:0] OUT_MIN   = 16'h8000;

  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_OUT = 4'd13;

  typedef enum logic [2:0] {
    A_DIFF_LS, A_DIFF_HS, A_LS, A_MID, A_MAG_HI, A_MAG_LO, A_T, A_RECIP
  } a_sel_e;

  typedef enum logic [2:0] {
    B_C_SLOW, B_C_FAST, B_LOW, B_MID, B_HIGH, B_HEAD, B_VOL, B_M
  } b_sel_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LS_UPD, OP_HS_UPD, OP_ACC_LD, OP_ACC_ADD,
    OP_ABS, OP_T_LD, OP_T_ADD, OP_M_LD, OP_OUT
  } op_e;

  typedef enum logic {
    JMP_NONE, JMP_ZERO
  } jmp_e;

  typedef struct packed {
    a_sel_e              a_sel;
    b_sel_e              b_sel;
    op_e                 op;
    jmp_e                jmp;
    logic [STEP_W-1:0]   target;
    logic                last;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w.a_sel  = A_LS;
    w.b_sel  = B_C_SLOW;
    w.op     = OP_NONE;
    w.jmp    = JMP_NONE;
    w.target = '0;
    w.last   = 1'b0;
    case (step)
      4'd0: begin
        w.a_sel = A_DIFF_LS; w.b_sel = B_C_SLOW;
      end
      4'd1: begin
        w.a_sel = A_DIFF_HS; w.b_sel = B_C_FAST; w.op = OP_LS_UPD;
      end
      4'd2: begin
        w.a_sel = A_LS; w.b_sel = B_LOW; w.op = OP_HS_UPD;
      end
      4'd3: begin
        w.a_sel = A_MID; w.b_sel = B_MID; w.op = OP_ACC_LD;
      end
      4'd4: begin
        w.a_sel = A_DIFF_HS; w.b_sel = B_HIGH; w.op = OP_ACC_ADD;
      end
      4'd5: begin
        w.op = OP_ACC_ADD;
      end
      4'd6: begin
        w.op = OP_ABS;
      end
      4'd7: begin
        // a zero band sum gives a zero product from here on: skip to output
        w.a_sel = A_MAG_HI; w.b_sel = B_HEAD; w.jmp = JMP_ZERO; w.target = STEP_OUT;
      end
      4'd8: begin
        w.a_sel = A_MAG_LO; w.b_sel = B_HEAD; w.op = OP_T_LD;
      end
      4'd9: begin
        w.op = OP_T_ADD;
      end
      4'd10: begin
        w.a_sel = A_T; w.b_sel = B_VOL;
      end
      4'd11: begin
        w.op = OP_M_LD;
      end
      4'd12: begin
        w.a_sel = A_RECIP; w.b_sel = B_M;
      end
      4'd13: begin
        w.op = OP_OUT; w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- sv/tbc_seq.sv -----
// ----------------------------------------------------------------------------
// Three-band tone control: microcode sequencer
// Step counter over the control table, with a conditional jump on a zero
// band sum and a hold while the output register is still occupied.
// ----------------------------------------------------------------------------
module tbc_seq
  import tbc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  mag_zero_i,
  input  logic  hold_i,
  output logic  run_o,
  output ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_e;

  seq_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  ctrl_t             ctrl;

  always_comb begin
    ctrl    = ucode(step_q);
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!hold_i) begin
          if (ctrl.last) begin
            state_d = ST_IDLE;
            step_d  = '0;
          end else if (ctrl.jmp == JMP_ZERO && mag_zero_i) begin
            step_d = ctrl.target;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign run_o  = (state_q == ST_RUN);
  assign ctrl_o = ctrl;

`ifndef NO_ASSERTIONS
  a_idle_step_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (step_q == '0))
    else $error("sequencer idle away from step zero");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_OUT)
    else $error("step counter beyond the program");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (state_q == ST_IDLE))
    else $error("start while the program runs");
`endif

endmodule

// ----- sv/three_band_tone_control_core.sv -----
// ----------------------------------------------------------------------------
// Three-band tone control core
// Two one-pole low-pass filters per channel split each sample into low, middle
// and high bands; weighted bands are scaled by headroom and volume/255,
// truncated toward zero and saturated to 16 bits.
//
//   channel  signals                                   dir
//   in       in_valid_i in_ready_o sample_in_i channel_i   in
//   out      out_valid_o out_ready_i sample_out_o clipped_o out
//   cfg      cfg_valid_i cfg_ready_o cfg_idx_i cfg_data_i   in
//
// Each sample runs 14 microcode steps through one shared 38x23 multiplier; the
// next is taken only after them, and a zero band sum skips to the output step.
// Reset clears filter state and sets unity gains, headroom and full volume.
// A finished beat waits in the output register; a new sample is taken
// meanwhile, and the last step holds only while that register is still full.
// Configuration beats are taken in every cycle.
// ----------------------------------------------------------------------------
module three_band_tone_control_core
  import tbc_pkg::*;
#(
  parameter int unsigned CHANNELS = TBC_CHANNELS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic signed [15:0]    sample_in_i,
  input  logic                  channel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [15:0]    sample_out_o,
  output logic                  clipped_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  ctrl_t ctrl;
  logic  run, hold, exec, start, mag_zero;

  logic [GAIN_W-1:0] low_gain_q, low_gain_d, mid_gain_q, mid_gain_d;
  logic [GAIN_W-1:0] high_gain_q, high_gain_d;
  logic [HEAD_W-1:0] headroom_q, headroom_d;
  logic [VOL_W-1:0]  volume_q, volume_d;

  logic signed [31:0] ls_st_q [CHANNELS];
  logic signed [31:0] hs_st_q [CHANNELS];

  logic [CH_W-1:0]     ch_idx, ch_q, ch_d;
  logic signed [31:0]  x_q, x_d, ls_w_q, ls_w_d, hs_w_q, hs_w_d;
  logic signed [ACC_W-1:0] acc_q, acc_d, acc_neg;
  logic [MAG_W-1:0]    mag_q, mag_d;
  logic                neg_q, neg_d;
  logic [T_W-1:0]      t_q, t_d;
  logic [BW-1:0]       m_q, m_d;
  logic [28:0]         m_full;
  logic signed [PW-1:0] p_q, p_d;

  logic signed [32:0]   diff_ls, diff_hs, mid;
  logic signed [AW-1:0] a_op;
  logic [BW-1:0]        b_op;

  logic [15:0] q_mag;
  logic [15:0] res_val;
  logic        res_clip;
  logic        out_valid_q, out_valid_d;
  logic [15:0] sample_out_q;
  logic        clipped_q;

  tbc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .mag_zero_i (mag_zero),
    .hold_i     (hold),
    .run_o      (run),
    .ctrl_o     (ctrl)
  );

  assign in_ready_o  = !run;
  assign cfg_ready_o = 1'b1;
  assign start       = in_valid_i && in_ready_o;
  assign hold        = run && ctrl.last && out_valid_q && !out_ready_i;
  assign exec        = run && !hold;
  assign mag_zero    = (mag_q == '0);
  assign ch_idx      = (CHANNELS > 1) ? CH_W'(channel_i) : '0;

  assign diff_ls = 33'(x_q) - 33'(ls_w_q);
  assign diff_hs = 33'(x_q) - 33'(hs_w_q);
  assign mid     = 33'(hs_w_q) - 33'(ls_w_q);

  always_comb begin
    case (ctrl.a_sel)
      A_DIFF_LS: a_op = AW'(diff_ls);
      A_DIFF_HS: a_op = AW'(diff_hs);
      A_LS:      a_op = AW'(ls_w_q);
      A_MID:     a_op = AW'(mid);
      A_MAG_HI:  a_op = AW'(mag_q[MAG_W-1:24]);
      A_MAG_LO:  a_op = AW'(mag_q[23:0]);
      A_T:       a_op = AW'(t_q);
      A_RECIP:   a_op = AW'(RECIP_255);
      default:   a_op = '0;
    endcase
    case (ctrl.b_sel)
      B_C_SLOW: b_op = BW'(C_SLOW);
      B_C_FAST: b_op = BW'(C_FAST);
      B_LOW:    b_op = BW'(low_gain_q);
      B_MID:    b_op = BW'(mid_gain_q);
      B_HIGH:   b_op = BW'(high_gain_q);
      B_HEAD:   b_op = BW'(headroom_q);
      B_VOL:    b_op = BW'(volume_q);
      B_M:      b_op = m_q;
      default:  b_op = '0;
    endcase
    p_d = PW'(a_op) * PW'($signed({1'b0, b_op}));
  end

  assign acc_neg = -acc_q;
  assign m_full  = p_q[44:16];
  assign q_mag   = p_q[47:32];

  always_comb begin
    if (neg_q) begin
      res_clip = (q_mag > NEG_LIMIT);
      res_val  = res_clip ? OUT_MIN : 16'(-q_mag);
    end else begin
      res_clip = (q_mag > POS_LIMIT);
      res_val  = res_clip ? OUT_MAX : q_mag;
    end
  end

  always_comb begin
    ch_d   = ch_q;
    x_d    = x_q;
    ls_w_d = ls_w_q;
    hs_w_d = hs_w_q;
    acc_d  = acc_q;
    mag_d  = mag_q;
    neg_d  = neg_q;
    t_d    = t_q;
    m_d    = m_q;
    if (start) begin
      ch_d   = ch_idx;
      x_d    = {sample_in_i, 16'h0000};
      ls_w_d = ls_st_q[ch_idx];
      hs_w_d = hs_st_q[ch_idx];
    end else if (exec) begin
      case (ctrl.op)
        OP_LS_UPD:  ls_w_d = ls_w_q + $signed(p_q[47:16]);
        OP_HS_UPD:  hs_w_d = hs_w_q + $signed(p_q[47:16]);
        OP_ACC_LD:  acc_d  = p_q[ACC_W-1:0];
        OP_ACC_ADD: acc_d  = acc_q + p_q[ACC_W-1:0];
        OP_ABS: begin
          neg_d = acc_q[ACC_W-1];
          mag_d = acc_q[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_q[MAG_W-1:0];
        end
        OP_T_LD:    t_d = p_q[T_W-1:0];
        OP_T_ADD:   t_d = t_q + T_W'(p_q[36:24]);
        OP_M_LD:    m_d = (m_full > 29'(M_CLAMP)) ? M_CLAMP : m_full[BW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    low_gain_d  = low_gain_q;
    mid_gain_d  = mid_gain_q;
    high_gain_d = high_gain_q;
    headroom_d  = headroom_q;
    volume_d    = volume_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_i)
        REG_LOW_GAIN:  low_gain_d  = cfg_data_i;
        REG_MID_GAIN:  mid_gain_d  = cfg_data_i;
        REG_HIGH_GAIN: high_gain_d = cfg_data_i;
        REG_HEADROOM:  headroom_d  = cfg_data_i[HEAD_W-1:0];
        REG_VOLUME:    volume_d    = cfg_data_i[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (exec && ctrl.op == OP_OUT) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_gain_q  <= GAIN_UNITY;
      mid_gain_q  <= GAIN_UNITY;
      high_gain_q <= GAIN_UNITY;
      headroom_q  <= HEAD_UNITY;
      volume_q    <= VOL_FULL;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        ls_st_q[i] <= '0;
        hs_st_q[i] <= '0;
      end
    end else begin
      low_gain_q  <= low_gain_d;
      mid_gain_q  <= mid_gain_d;
      high_gain_q <= high_gain_d;
      headroom_q  <= headroom_d;
      volume_q    <= volume_d;
      out_valid_q <= out_valid_d;
      if (exec && ctrl.op == OP_OUT) begin
        ls_st_q[ch_q] <= ls_w_q;
        hs_st_q[ch_q] <= hs_w_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    x_q    <= x_d;
    ls_w_q <= ls_w_d;
    hs_w_q <= hs_w_d;
    acc_q  <= acc_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    t_q    <= t_d;
    m_q    <= m_d;
    if (exec) begin
      p_q <= p_d;
    end
    if (exec && ctrl.op == OP_OUT) begin
      sample_out_q <= res_val;
      clipped_q    <= res_clip;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = $signed(sample_out_q);
  assign clipped_o    = clipped_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken without starting the program");

  a_result_from_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(run && ctrl.last))
    else $error("result beat raised outside the output step");
`endif

endmodule

// ----- tb/tb_three_band_tone_control_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench: three-band tone control core
// Streams interleaved stereo PCM through the core with random gaps and stalls
// on both handshakes. A cycle-free model of the two one-pole filters and the
// gain, headroom and volume chain predicts every output beat. Sample and clip
// flag are compared beat by beat under several register settings, including
// the extremes and out-of-range values.
// ----------------------------------------------------------------------------
module tb_three_band_tone_control_core
  import tbc_pkg::*;
();

  localparam int GAIN_MIN    = 1029;
  localparam int GAIN_MAX    = 16306;
  localparam int HOLD_CYCLES = 200;

  typedef struct {
    int unsigned        seq;
    logic signed [15:0] smp;
    logic               clip;
  } shaped_beat_t;

  class tone_scoreboard;
    logic [GAIN_W-1:0] low_gain, mid_gain, high_gain;
    logic [HEAD_W-1:0] headroom;
    logic [VOL_W-1:0]  volume;
    int                low_band[TBC_CHANNELS];
    int                fast_band[TBC_CHANNELS];
    shaped_beat_t      shaped_q[$];
    int unsigned       accepted;
    int unsigned       failures;

    function new();
      low_gain  = GAIN_UNITY;
      mid_gain  = GAIN_UNITY;
      high_gain = GAIN_UNITY;
      headroom  = HEAD_UNITY;
      volume    = VOL_FULL;
      foreach (low_band[i]) begin
        low_band[i]  = 0;
        fast_band[i] = 0;
      end
      accepted = 0;
      failures = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LOW_GAIN:  low_gain  = data[GAIN_W-1:0];
        REG_MID_GAIN:  mid_gain  = data[GAIN_W-1:0];
        REG_HIGH_GAIN: high_gain = data[GAIN_W-1:0];
        REG_HEADROOM:  headroom  = data[HEAD_W-1:0];
        REG_VOLUME:    volume    = data[VOL_W-1:0];
        default: ;
      endcase
    endfunction

    // new state = s + floor(coef * (x - s) / 2^16)
    function int lowpass(int s, longint x, longint coef);
      longint delta;
      delta = (coef * (x - longint'(s))) >>> 16;
      return int'(longint'(s) + delta);
    endfunction

    function void note_sample(logic signed [15:0] smp, logic ch);
      int           idx;
      longint       x, lo, mid, hi, acc, t, r;
      shaped_beat_t b;
      idx            = int'(ch) % TBC_CHANNELS;
      x              = longint'(smp) * 65536;
      low_band[idx]  = lowpass(low_band[idx], x, longint'(C_SLOW));
      fast_band[idx] = lowpass(fast_band[idx], x, longint'(C_FAST));
      lo  = longint'(low_band[idx]);
      mid = longint'(fast_band[idx]) - lo;
      hi  = x - longint'(fast_band[idx]);
      acc = lo * longint'(low_gain) + mid * longint'(mid_gain) + hi * longint'(high_gain);
      t   = (acc * longint'(headroom)) / (longint'(1) << 24);
      r   = (t * longint'(volume)) / (longint'(255) * 65536);
      b.clip = 1'b0;
      if (r > 32767) begin
        r      = 32767;
        b.clip = 1'b1;
      end
      if (r < -32768) begin
        r      = -32768;
        b.clip = 1'b1;
      end
      b.smp = r[15:0];
      b.seq = accepted;
      accepted++;
      shaped_q.push_back(b);
    endfunction

    function void check_beat(logic signed [15:0] got_s, logic got_c);
      shaped_beat_t b;
      if (shaped_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected output beat: sample %0d clipped %0b", got_s, got_c);
        return;
      end
      b = shaped_q.pop_front();
      if (got_s !== b.smp || got_c !== b.clip) begin
        failures++;
        if (failures <= 10)
          $display("beat %0d: expected sample %0d clipped %0b, got sample %0d clipped %0b",
                   b.seq, b.smp, b.clip, got_s, got_c);
      end
    endfunction

    function int pending();
      return shaped_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_ready_o;
  logic signed [15:0]    sample_in;
  logic                  channel_in;
  logic                  out_valid_o;
  logic                  out_ready;
  logic signed [15:0]    sample_out_o;
  logic                  clipped_o;
  logic                  cfg_valid;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  tone_scoreboard sb = new();
  bit             quiet;
  bit             hold_req;
  int             walk[TBC_CHANNELS];

  three_band_tone_control_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in),
    .channel_i    (channel_in),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) sb.write_reg(cfg_idx, cfg_data);
      if (in_valid && in_ready_o) sb.note_sample(sample_in, channel_in);
      if (out_valid_o && out_ready) sb.check_beat(sample_out_o, clipped_o);
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_ready <= 1'b1;
        hold_req = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (stall - 1) @(negedge clk_i);
        end
      end
    end
  end

  task automatic send_sample(input logic signed [15:0] smp, input logic ch);
    int gap;
    @(negedge clk_i);
    in_valid   <= 1'b1;
    sample_in  <= smp;
    channel_in <= ch;
    do @(posedge clk_i); while (!in_ready_o);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // drop valid, drain every outstanding beat and let the datapath go idle
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input int lg, input int mg, input int hg, input int hr, input int vol);
    write_reg(REG_LOW_GAIN, CFG_DATA_W'(lg));
    write_reg(REG_MID_GAIN, CFG_DATA_W'(mg));
    write_reg(REG_HIGH_GAIN, CFG_DATA_W'(hg));
    write_reg(REG_HEADROOM, CFG_DATA_W'(hr));
    write_reg(REG_VOLUME, CFG_DATA_W'(vol));
  endtask

  function automatic int pick_gain();
    case ($urandom_range(0, 9))
      0: return GAIN_MIN;
      1: return GAIN_MAX;
      2: return int'(GAIN_UNITY);
      3: return $urandom_range(0, 2**CFG_DATA_W - 1);
      default: return $urandom_range(GAIN_MIN, GAIN_MAX);
    endcase
  endfunction

  function automatic logic signed [15:0] next_sample(logic ch);
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 30) v = int'($urandom_range(0, 65535)) - 32768;
    else if (r < 42) v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
    else if (r < 52) v = int'($urandom_range(0, 511)) - 256;
    else begin
      v = walk[ch] + int'($urandom_range(0, 4095)) - 2048;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
    end
    walk[ch] = v;
    return v[15:0];
  endfunction

  task automatic run_phase(input int n_items, input bit matched);
    int   lg, mg, hg, hr, vol, top;
    logic ch;
    lg  = pick_gain();
    mg  = pick_gain();
    hg  = pick_gain();
    top = (lg > mg) ? lg : mg;
    top = (hg > top) ? hg : top;
    if (matched) begin
      hr = (top <= int'(HEAD_UNITY)) ? int'(HEAD_UNITY) : (1 << 24) / top;
    end else begin
      case ($urandom_range(0, 5))
        0: hr = GAIN_MIN;
        1: hr = int'(HEAD_UNITY);
        2: hr = $urandom_range(0, 2**CFG_DATA_W - 1);
        default: hr = $urandom_range(GAIN_MIN, int'(HEAD_UNITY));
      endcase
    end
    case ($urandom_range(0, 7))
      0: vol = 0;
      1: vol = int'(VOL_FULL);
      2: vol = $urandom_range(0, 2**CFG_DATA_W - 1);
      default: vol = $urandom_range(0, int'(VOL_FULL));
    endcase
    write_all(lg, mg, hg, hr, vol);
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(int'(REG_VOLUME) + 1, 2**CFG_IDX_W - 1)),
                CFG_DATA_W'($urandom_range(0, 2**CFG_DATA_W - 1)));
    ch = 1'($urandom_range(0, 1));
    for (int i = 0; i < n_items; i++) begin
      ch = ($urandom_range(0, 99) < 85) ? ~ch : 1'($urandom_range(0, 1));
      send_sample(next_sample(ch), ch);
    end
    settle();
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    sample_in  = '0;
    channel_in = 1'b0;
    cfg_valid  = 1'b0;
    cfg_idx    = REG_LOW_GAIN;
    cfg_data   = '0;
    quiet      = 1'b1;
    hold_req   = 1'b0;
    foreach (walk[i]) walk[i] = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: zero band sum, full-scale steps on both channels
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd1, 1'b1);
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b1);
    settle();

    // unused indexes must be ignored; full-width gains force saturation
    for (int i = int'(REG_VOLUME) + 1; i < 2**CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), '1);
    write_all(2**GAIN_W - 1, 2**GAIN_W - 1, 2**GAIN_W - 1, 2**CFG_DATA_W - 1,
              2**CFG_DATA_W - 1);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    settle();

    // zero gains and zero volume
    write_all(0, 0, 0, 0, 16'h3F00);
    send_sample(16'sd12345, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    settle();
    write_all(int'(GAIN_UNITY), int'(GAIN_UNITY), int'(GAIN_UNITY), int'(HEAD_UNITY), 0);
    send_sample(16'sd32767, 1'b0);
    settle();

    // smallest stated settings
    write_all(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, 1);
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    settle();

    for (int p = 0; p < 8; p++) begin
      quiet = (p == 0 || p == 5);
      if (p == 3) hold_req = 1'b1;
      run_phase(118, (p % 2) == 0);
    end

    repeat (30) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- three_band_tone_control_core.f -----
sv/tbc_pkg.sv
sv/tbc_seq.sv
sv/three_band_tone_control_core.sv
tb/tb_three_band_tone_control_core.sv
